[sv/pgmhp_pkg.sv]
// Package for the PGM header parser: item types, phase encoding, byte and status constants, and a whitespace test.
// No dependencies.
package pgmhp_pkg;

  typedef struct packed {
    logic       start_req;
    logic [7:0] byte_in;
  } pgmhp_in_t;

  typedef struct packed {
    logic        status;
    logic        mode;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] grey_max;
    logic        comment_seen;
  } pgmhp_out_t;

  typedef enum logic [2:0] {
    PH_MAGIC0 = 3'd0,
    PH_MAGIC1 = 3'd1,
    PH_MAGIC2 = 3'd2,
    PH_FIELDS = 3'd3,
    PH_DONE   = 3'd4,
    PH_BAD1   = 3'd5,
    PH_BAD2   = 3'd6
  } pgmhp_phase_e;

  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] Ch2     = 8'h32;
  localparam logic [7:0] Ch5     = 8'h35;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  function automatic logic is_space(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChCr) || (b == ChLf);
  endfunction

endpackage

[sv/pgm_header_parser.sv]
// Top level of the PGM header parser: input register, parser core, result register.
// Depends on pgmhp_pkg, pgmhp_in_reg, pgmhp_core, pgmhp_out_reg.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | in_item_i  (pgmhp_in_t)
//   out     | output    | out_valid_o/out_ready_i | out_item_o (pgmhp_out_t)
//
// One byte per cycle sustained while no result is stalled.
// The byte is processed when it leaves the input register into a free result register.
// Reset clears all parser state; the first byte after reset is a magic byte.
// A stalled result blocks processing, and the input register then fills and drops ready.
module pgm_header_parser import pgmhp_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pgmhp_in_t  in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pgmhp_out_t out_item_o
);

  logic       s1_valid;
  pgmhp_in_t  s1_item;
  logic       out_free;
  logic       adv;
  logic       res_valid;
  pgmhp_out_t res;

  assign adv = s1_valid && out_free;

  pgmhp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  pgmhp_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pgmhp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[sv/pgmhp_in_reg.sv]
// Input register stage of the PGM header parser: holds one accepted item.
// Depends on pgmhp_pkg.
module pgmhp_in_reg import pgmhp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pgmhp_in_t in_item_i,
  input  logic      adv_i,
  output logic      valid_o,
  output pgmhp_in_t item_o
);

  logic      valid_q, valid_d;
  pgmhp_in_t item_q;
  logic      load;

  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/pgmhp_core.sv]
// Parser state and per-byte next-state logic of the PGM header parser.
// Depends on pgmhp_pkg.
module pgmhp_core import pgmhp_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  pgmhp_in_t  item_i,
  output logic       res_valid_o,
  output pgmhp_out_t res_o
);

  localparam int AW = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VMax = '1;

  pgmhp_phase_e          phase_q, phase_d;
  logic [1:0]            fidx_q, fidx_d;
  logic                  in_tok_q, in_tok_d;
  logic                  in_cmt_q, in_cmt_d;
  logic                  dstop_q, dstop_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [VALUE_BITS-1:0] wid_q, wid_d;
  logic [VALUE_BITS-1:0] hgt_q, hgt_d;
  logic                  mode_q, mode_d;
  logic                  cflag_q, cflag_d;

  logic [7:0]            b;
  logic                  st;
  logic                  is_dig;
  logic [AW-1:0]         acc_ext;
  logic [AW-1:0]         prod;
  logic [VALUE_BITS-1:0] acc_sat;
  logic [VALUE_BITS+15:0] w_ext, h_ext, g_ext;

  assign b      = item_i.byte_in;
  assign st     = item_i.start_req;
  assign is_dig = (b >= ChZero) && (b <= ChNine);

  // digit accumulate base: cleared on a start request or a fresh token
  always_comb begin
    acc_ext = {4'b0, acc_q};
    if (st || !in_tok_q) begin
      acc_ext = '0;
    end
    prod    = (acc_ext << 3) + (acc_ext << 1) + {{(AW-4){1'b0}}, b[3:0]};
    acc_sat = (prod > {4'b0, VMax}) ? VMax : prod[VALUE_BITS-1:0];
  end

  always_comb begin
    pgmhp_phase_e ph;
    logic [1:0]   fi;
    logic         tk, cm, ds, md, cf;
    ph = st ? PH_MAGIC0 : phase_q;
    fi = st ? 2'd0 : fidx_q;
    tk = st ? 1'b0 : in_tok_q;
    cm = st ? 1'b0 : in_cmt_q;
    ds = st ? 1'b0 : dstop_q;
    md = st ? 1'b0 : mode_q;
    cf = st ? 1'b0 : cflag_q;

    phase_d  = ph;
    fidx_d   = fi;
    in_tok_d = tk;
    in_cmt_d = cm;
    dstop_d  = ds;
    acc_d    = st ? '0 : acc_q;
    wid_d    = st ? '0 : wid_q;
    hgt_d    = st ? '0 : hgt_q;
    mode_d   = md;
    cflag_d  = cf;

    res_valid_o = 1'b0;
    w_ext = {16'b0, wid_d};
    h_ext = {16'b0, hgt_d};
    g_ext = {16'b0, acc_d};
    res_o = '0;
    res_o.status = STATUS_BAD;

    case (ph)
      PH_MAGIC0: begin
        phase_d = (b == ChP) ? PH_MAGIC1 : PH_BAD1;
      end
      PH_MAGIC1: begin
        if (b == Ch2) begin
          mode_d  = 1'b0;
          phase_d = PH_MAGIC2;
        end else if (b == Ch5) begin
          mode_d  = 1'b1;
          phase_d = PH_MAGIC2;
        end else begin
          phase_d = PH_BAD2;
        end
      end
      PH_BAD1: begin
        phase_d = PH_BAD2;
      end
      PH_MAGIC2: begin
        if (is_space(b)) begin
          phase_d = PH_FIELDS;
        end else begin
          phase_d     = PH_DONE;
          res_valid_o = 1'b1;
        end
      end
      PH_BAD2: begin
        phase_d     = PH_DONE;
        res_valid_o = 1'b1;
      end
      PH_FIELDS: begin
        if (!tk) begin
          if (!is_space(b)) begin
            in_tok_d = 1'b1;
            if (b == ChHash) begin
              in_cmt_d = 1'b1;
              cflag_d  = 1'b1;
            end else begin
              in_cmt_d = 1'b0;
              dstop_d  = !is_dig;
              acc_d    = is_dig ? acc_sat : '0;
            end
          end
        end else if (cm) begin
          if (is_space(b) && (b != ChSpace)) begin
            in_tok_d = 1'b0;
            in_cmt_d = 1'b0;
          end
        end else if (!is_space(b)) begin
          if (!ds) begin
            if (is_dig) begin
              acc_d = acc_sat;
            end else begin
              dstop_d = 1'b1;
            end
          end
        end else begin
          in_tok_d = 1'b0;
          case (fi)
            2'd0: begin
              wid_d  = acc_q;
              fidx_d = 2'd1;
            end
            2'd1: begin
              hgt_d  = acc_q;
              fidx_d = 2'd2;
            end
            default: begin
              phase_d      = PH_DONE;
              res_valid_o  = 1'b1;
              w_ext        = {16'b0, wid_q};
              h_ext        = {16'b0, hgt_q};
              g_ext        = {16'b0, acc_q};
              res_o.status       = STATUS_OK;
              res_o.mode         = md;
              res_o.image_width  = w_ext[15:0];
              res_o.image_height = h_ext[15:0];
              res_o.grey_max     = g_ext[15:0];
              res_o.comment_seen = cf;
            end
          endcase
        end
      end
      default: begin
        phase_d = ph;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC0;
      fidx_q   <= 2'd0;
      in_tok_q <= 1'b0;
      in_cmt_q <= 1'b0;
      dstop_q  <= 1'b0;
      acc_q    <= '0;
      wid_q    <= '0;
      hgt_q    <= '0;
      mode_q   <= 1'b0;
      cflag_q  <= 1'b0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      fidx_q   <= fidx_d;
      in_tok_q <= in_tok_d;
      in_cmt_q <= in_cmt_d;
      dstop_q  <= dstop_d;
      acc_q    <= acc_d;
      wid_q    <= wid_d;
      hgt_q    <= hgt_d;
      mode_q   <= mode_d;
      cflag_q  <= cflag_d;
    end
  end

endmodule

[sv/pgmhp_out_reg.sv]
// Result register of the PGM header parser: holds one result item until taken.
// Depends on pgmhp_pkg.
module pgmhp_out_reg import pgmhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  pgmhp_out_t res_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pgmhp_out_t out_item_o
);

  logic       valid_q, valid_d;
  pgmhp_out_t item_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

[sv/pgmhp_checker.sv]
// Port-level checks for the PGM header parser, bound to the top level.
// Depends on pgmhp_pkg and pgm_header_parser.
module pgmhp_checker import pgmhp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input pgmhp_in_t  in_item_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input pgmhp_out_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == STATUS_BAD) |->
      !out_item_o.mode && (out_item_o.image_width == '0) &&
      (out_item_o.image_height == '0) && (out_item_o.grey_max == '0) &&
      !out_item_o.comment_seen)
    else $error("bad magic result carries data");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  a_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.start_req |=> ##1 !$rose(out_valid_o))
    else $error("result caused by a start byte");

endmodule

bind pgm_header_parser pgmhp_checker u_pgmhp_checker (.*);
